/* sv/ildl_pkg.sv */
// Shared types, codes and constants for the indexed doubly linked list.
`timescale 1ns / 1ps

package ildl_pkg;

    // Node values and pointers carried on the ports and in the stores
    localparam int FIELD_W       = 10;
    localparam int OP_W          = 2;
    localparam int DEFAULT_NODES = 1024;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Store write selections issued by the controller
    localparam int WSEL_W = 3;
    localparam logic [WSEL_W-1:0] WR_NONE     = 3'd0;
    localparam logic [WSEL_W-1:0] WR_INIT0    = 3'd1;
    localparam logic [WSEL_W-1:0] WR_INIT1    = 3'd2;
    localparam logic [WSEL_W-1:0] WR_INS_LINK = 3'd3;
    localparam logic [WSEL_W-1:0] WR_INS_FIX  = 3'd4;
    localparam logic [WSEL_W-1:0] WR_DEL_LINK = 3'd5;

    // Controller to datapath command
    typedef struct packed {
        logic              load;    // capture transaction, read both stores at anchor
        logic [WSEL_W-1:0] wr_sel;  // which pointer pair to write this cycle
    } dp_cmd_t;

endpackage

/* sv/ildl_datapath.sv */
// Datapath: successor and predecessor stores, operand registers, write steering.
`timescale 1ns / 1ps

module ildl_datapath
    import ildl_pkg::*;
#(
    parameter int NODES = DEFAULT_NODES
)
(
    input  logic               clk,
    input  dp_cmd_t            cmd,
    input  logic [FIELD_W-1:0] anchor,
    input  logic [FIELD_W-1:0] new_node,
    output logic [FIELD_W-1:0] successor
);

    localparam int AW = $clog2(NODES);
    localparam int RW = (AW > FIELD_W) ? AW : FIELD_W;

    // Node value to store slot: value mod NODES by restoring subtraction.
    // A 10-bit value over NODES >= 4 has a quotient below 256: eight steps.
    function automatic logic [AW-1:0] slot(input logic [FIELD_W-1:0] v);
        logic [RW-1:0] r;
        r = RW'(v);
        for (int k = 7; k >= 0; k--)
        begin
            if (32'(r) >= (NODES << k))
            begin
                r = r - RW'(NODES << k);
            end
        end
        return r[AW-1:0];
    endfunction

    logic [FIELD_W-1:0] next_mem_reg [NODES];
    logic [FIELD_W-1:0] prev_mem_reg [NODES];

    logic [FIELD_W-1:0] next_rd_reg;
    logic [FIELD_W-1:0] prev_rd_reg;
    logic [FIELD_W-1:0] anchor_reg;
    logic [FIELD_W-1:0] node_reg;
    logic [AW-1:0]      anchor_slot_reg;
    logic [AW-1:0]      node_slot_reg;

    logic [AW-1:0]      rd_addr;
    logic               n_we;
    logic [AW-1:0]      n_wa;
    logic [FIELD_W-1:0] n_wd;
    logic               p_we;
    logic [AW-1:0]      p_wa;
    logic [FIELD_W-1:0] p_wd;

    assign rd_addr   = slot(anchor);
    assign successor = next_rd_reg;

    // operand capture at the accepting edge
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            anchor_reg      <= anchor;
            node_reg        <= new_node;
            anchor_slot_reg <= rd_addr;
            node_slot_reg   <= slot(new_node);
        end
    end

    // Write order within one insert: the pair in the link step lands before
    // the pair in the fix step, so a later write to the same slot wins.
    always_comb
    begin
        n_we = 1'b0;
        n_wa = '0;
        n_wd = '0;
        p_we = 1'b0;
        p_wa = '0;
        p_wd = '0;
        case (cmd.wr_sel)
            WR_INIT0:
            begin
                n_we = 1'b1;
                n_wa = AW'(0);
                n_wd = FIELD_W'(1);
                p_we = 1'b1;
                p_wa = AW'(0);
                p_wd = FIELD_W'(1);
            end
            WR_INIT1:
            begin
                n_we = 1'b1;
                n_wa = AW'(1);
                n_wd = FIELD_W'(0);
                p_we = 1'b1;
                p_wa = AW'(1);
                p_wd = FIELD_W'(0);
            end
            WR_INS_LINK:
            begin
                p_we = 1'b1;
                p_wa = slot(next_rd_reg);
                p_wd = node_reg;
                n_we = 1'b1;
                n_wa = node_slot_reg;
                n_wd = next_rd_reg;
            end
            WR_INS_FIX:
            begin
                n_we = 1'b1;
                n_wa = anchor_slot_reg;
                n_wd = node_reg;
                p_we = 1'b1;
                p_wa = node_slot_reg;
                p_wd = anchor_reg;
            end
            WR_DEL_LINK:
            begin
                n_we = 1'b1;
                n_wa = slot(prev_rd_reg);
                n_wd = next_rd_reg;
                p_we = 1'b1;
                p_wa = slot(next_rd_reg);
                p_wd = prev_rd_reg;
            end
            default:
            begin
                n_we = 1'b0;
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            next_mem_reg[n_wa] <= n_wd;
        end
        if (cmd.load)
        begin
            next_rd_reg <= next_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            prev_mem_reg[p_wa] <= p_wd;
        end
        if (cmd.load)
        begin
            prev_rd_reg <= prev_mem_reg[rd_addr];
        end
    end

endmodule

/* sv/ildl_ctrl.sv */
// Controller: sequences store init, insert, delete and query transactions.
`timescale 1ns / 1ps

module ildl_ctrl
    import ildl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] op,
    output logic            busy,
    output logic            result_valid,
    output dp_cmd_t         cmd
);

    localparam logic [2:0] ST_INIT0    = 3'd0;
    localparam logic [2:0] ST_INIT1    = 3'd1;
    localparam logic [2:0] ST_IDLE     = 3'd2;
    localparam logic [2:0] ST_INS_LINK = 3'd3;
    localparam logic [2:0] ST_INS_FIX  = 3'd4;
    localparam logic [2:0] ST_DEL_LINK = 3'd5;
    localparam logic [2:0] ST_QRY      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign accept       = start && (state_reg == ST_IDLE);
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_QRY);

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = accept;
        cmd.wr_sel = WR_NONE;
        case (state_reg)
            ST_INIT0:
            begin
                cmd.wr_sel = WR_INIT0;
                state_next = ST_INIT1;
            end
            ST_INIT1:
            begin
                cmd.wr_sel = WR_INIT1;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_INSERT: state_next = ST_INS_LINK;
                        OP_QUERY:  state_next = ST_QRY;
                        OP_DELETE: state_next = ST_DEL_LINK;
                        default:   state_next = ST_IDLE;  // unused opcode
                    endcase
                end
            end
            ST_INS_LINK:
            begin
                cmd.wr_sel = WR_INS_LINK;
                state_next = ST_INS_FIX;
            end
            ST_INS_FIX:
            begin
                cmd.wr_sel = WR_INS_FIX;
                state_next = ST_IDLE;
            end
            ST_DEL_LINK:
            begin
                cmd.wr_sel = WR_DEL_LINK;
                state_next = ST_IDLE;
            end
            ST_QRY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/indexed_doubly_linked_list.sv */
// Top level of the indexed doubly linked list: controller plus datapath.
`timescale 1ns / 1ps

// Doubly linked list of node values kept in two stores indexed by node
// (successor and predecessor), with node 0 as a circular sentinel whose
// successor is the front and whose predecessor is the tail. After reset the
// list holds node 1 alone. A transaction is taken at a rising edge with
// start high and busy low. op selects insert (link new_node after anchor,
// anchor 0 meaning the front), query (report the successor of anchor, 0 at
// the tail) or delete (unlink anchor); the unused opcode is taken and dropped.
// Inputs are trusted: the anchor must be in the list and an inserted node
// must not be. Timing is fixed by the one write port on each store. Both
// stores are read at the accepting edge; busy then stays high through the
// link and fix states on insert (two pointer writes into each store), the
// link state on delete (one write into each store) and the result state on
// query, and stays low on the unused opcode. A query result appears on
// successor with result_valid high for exactly one cycle, the cycle after the
// accepting edge; there is no back-pressure, so the receiver must take it
// then. busy is still high during that result cycle, so the next transaction
// is taken at the edge after it at the earliest. busy stays high after reset
// release while the init states write the sentinel and node 1 into the
// stores; all other store entries are undefined until linked. NODES sets the
// store depth; node values are reduced modulo NODES to address the stores.

module indexed_doubly_linked_list
    import ildl_pkg::*;
#(
    parameter int NODES = DEFAULT_NODES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    op,
    input  logic [FIELD_W-1:0] anchor,
    input  logic [FIELD_W-1:0] new_node,
    output logic               result_valid,
    output logic [FIELD_W-1:0] successor
);

    dp_cmd_t cmd;

    // Sequencer: owns the transaction handshake and the result strobe.
    ildl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // Stores and operand registers; successor is the registered store read.
    ildl_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .anchor    (anchor),
        .new_node  (new_node),
        .successor (successor)
    );

endmodule

/* sv/ildl_checker.sv */
// Port-level checker for the indexed doubly linked list, bound to the top level.
`timescale 1ns / 1ps

module ildl_checker
    import ildl_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic [OP_W-1:0] op,
    input logic            result_valid
);

    logic take;

    assign take = start && !busy;

    // a query transaction yields its result in the next cycle
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && op == OP_QUERY) |=> result_valid)
        else $error("query transaction without result");

    // no result strobe unless a query was taken in the cycle before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(take && op == OP_QUERY))
        else $error("result strobe without query");

    // results are never back to back
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held two cycles");

    // insert holds busy through its link and fix states, then drops it
    a_insert_len: assert property (@(posedge clk) disable iff (!rst_n)
        (take && op == OP_INSERT) |=> busy ##1 busy ##1 !busy)
        else $error("insert length wrong");

    // delete holds busy through its link state, then drops it
    a_delete_len: assert property (@(posedge clk) disable iff (!rst_n)
        (take && op == OP_DELETE) |=> busy ##1 !busy)
        else $error("delete length wrong");

endmodule

bind indexed_doubly_linked_list ildl_checker u_ildl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .result_valid (result_valid)
);

/* sim/indexed_doubly_linked_list_test.sv */
// Self-checking testbench for the indexed doubly linked list block.
`timescale 1ns / 1ps

// Stimulus runs in three parts:
//   1. A directed table: front, middle and tail inserts, deletes at both ends,
//      draining the list to empty and refilling it, the unused opcode, and a
//      query of an unlinked node. Rows whose answer is obvious carry it
//      inline. The other rows are checked against the shadow list below.
//   2. Random well-formed traffic in four phases with different list size
//      caps and varying sender idle rates. Insert and delete anchors are
//      always linked nodes and inserted nodes are always absent.
//   3. A short tail of untrusted transactions: a random opcode, any new node
//      (0 and linked nodes included), deleting the sentinel and so on. The
//      only rule kept here is that the anchor's store entries have been
//      written. Every pointer read is indexed by the anchor, so no entry that
//      was never written is ever read.
// A shadow copy of both pointer stores predicts each query without an inline
// answer. Results are checked in order against a FIFO of expected successors.

module indexed_doubly_linked_list_test;
    import ildl_pkg::*;

    typedef logic [FIELD_W-1:0] node_t;

    // op 3 has no name in the package; the block takes it and drops it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int NUM_NODES      = DEFAULT_NODES;
    localparam int MAX_GAP        = 40;   // longest sender idle run
    localparam int DRAIN_CYCLES   = 8;    // settle time after the last result
    localparam int WATCHDOG_LIMIT = 500;  // cycles with no transaction at all
    localparam int PHASE_ITEMS    = 410;
    localparam int TAIL_ITEMS     = 40;

    // One directed row. When known is set, want is the literal answer to
    // a query row. Otherwise the shadow list supplies it.
    typedef struct packed {
        logic [OP_W-1:0] op;
        node_t           anchor;
        node_t           new_node;
        logic            known;
        node_t           want;
    } stim_row_t;

    localparam int NUM_ROWS = 25;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd1},    // reset state: 0 -> 1
        '{OP_QUERY,  10'd1,    10'd0,    1'b1, 10'd0},    // node 1 is the tail
        '{OP_INSERT, 10'd0,    10'd1023, 1'b0, 10'd0},    // insert at the front
        '{OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd1023},
        '{OP_QUERY,  10'd1023, 10'd0,    1'b1, 10'd1},
        '{OP_INSERT, 10'd1,    10'd2,    1'b0, 10'd0},    // append after the tail
        '{OP_QUERY,  10'd1,    10'd0,    1'b1, 10'd2},
        '{OP_QUERY,  10'd2,    10'd0,    1'b1, 10'd0},
        '{OP_INSERT, 10'd1023, 10'd512,  1'b0, 10'd0},    // insert in the middle
        '{OP_QUERY,  10'd1023, 10'd0,    1'b0, 10'd0},
        '{OP_DELETE, 10'd1023, 10'd0,    1'b0, 10'd0},    // unlink the front
        '{OP_QUERY,  10'd0,    10'd0,    1'b0, 10'd0},
        '{OP_DELETE, 10'd2,    10'd0,    1'b0, 10'd0},    // unlink the tail
        '{OP_QUERY,  10'd1,    10'd0,    1'b1, 10'd0},
        '{OP_UNUSED, 10'd1023, 10'd1023, 1'b0, 10'd0},    // dropped, no result
        '{OP_QUERY,  10'd0,    10'd0,    1'b0, 10'd0},
        '{OP_INSERT, 10'd512,  10'd511,  1'b0, 10'd0},
        '{OP_DELETE, 10'd1,    10'd0,    1'b0, 10'd0},
        '{OP_QUERY,  10'd1,    10'd0,    1'b0, 10'd0},    // unlinked node keeps its link
        '{OP_DELETE, 10'd512,  10'd0,    1'b0, 10'd0},
        '{OP_DELETE, 10'd511,  10'd0,    1'b0, 10'd0},    // list is now empty
        '{OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd0},    // sentinel points at itself
        '{OP_INSERT, 10'd0,    10'd1,    1'b0, 10'd0},    // refill an empty list
        '{OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd1},
        '{OP_QUERY,  10'd1,    10'd0,    1'b1, 10'd0}
    };

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [OP_W-1:0] op;
    node_t           anchor;
    node_t           new_node;
    logic            result_valid;
    node_t           successor;

    // Shadow pointer stores, plus flags for entries written since reset
    node_t nxt_link [NUM_NODES];
    node_t prv_link [NUM_NODES];
    bit    nxt_set  [NUM_NODES];
    bit    prv_set  [NUM_NODES];

    // Linked nodes, sentinel excluded, as seen by the well-formed traffic
    node_t linked_nodes [$];
    bit    is_linked    [NUM_NODES];

    node_t pending_successors [$];   // answers still owed by the block
    int    error_count;
    int    stall_cycles;
    int    sender_idle_pct;
    node_t owed;

    indexed_doubly_linked_list #(.NODES(NUM_NODES)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .anchor       (anchor),
        .new_node     (new_node),
        .result_valid (result_valid),
        .successor    (successor)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Apply one transaction to the shadow stores. The pointer writes follow
    // the block's fixed order, and each read sees the earlier writes. That
    // order also covers untrusted inserts and deletes.
    task automatic list_step(input logic [OP_W-1:0] o, input node_t a, input node_t y,
                             output bit has_answer, output node_t answer);
        has_answer = 1'b0;
        answer     = '0;
        case (o)
            OP_INSERT: begin
                prv_link[nxt_link[a]] = y;
                prv_set[nxt_link[a]]  = 1'b1;
                nxt_link[y]           = nxt_link[a];
                nxt_set[y]            = 1'b1;
                nxt_link[a]           = y;
                prv_link[y]           = a;
                prv_set[y]            = 1'b1;
            end
            OP_QUERY: begin
                has_answer = 1'b1;
                answer     = nxt_link[a];
            end
            OP_DELETE: begin
                nxt_link[prv_link[a]] = nxt_link[a];
                nxt_set[prv_link[a]]  = 1'b1;
                prv_link[nxt_link[a]] = prv_link[a];
                prv_set[nxt_link[a]]  = 1'b1;
            end
            default: ;   // unused opcode: no state change
        endcase
    endtask

    // A random node whose two store entries are both written. The sentinel is
    // the fallback.
    function automatic node_t pick_written_node();
        node_t cand;
        for (int i = 0; i < 64; i++) begin
            cand = node_t'($urandom_range(0, NUM_NODES - 1));
            if (nxt_set[cand] && prv_set[cand])
                return cand;
        end
        return '0;
    endfunction

    // Drive one transaction. It may idle first. Hold it until it is
    // accepted, then predict. Inputs change on the falling edge. Acceptance is
    // sampled on the rising edge. start is only written once per edge, so
    // back-to-back transactions keep it high.
    task automatic send_item(input logic [OP_W-1:0] o, input node_t a, input node_t y,
                             input bit known, input node_t want);
        int    gap;
        bit    has_answer;
        node_t answer;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        op       <= o;
        anchor   <= a;
        new_node <= y;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        list_step(o, a, y, has_answer, answer);
        if (has_answer)
            pending_successors.push_back(known ? want : answer);
    endtask

    // One well-formed random transaction. The list grows up to cap nodes.
    task automatic random_item(input int cap);
        int    n;
        int    pick;
        int    idx;
        node_t a;
        node_t y;
        n    = linked_nodes.size();
        pick = $urandom_range(99);
        idx  = $urandom_range(0, n);
        a    = (idx == 0) ? node_t'(0) : linked_nodes[idx - 1];
        if (pick < 3) begin
            // noise: the block drops it
            send_item(OP_UNUSED, pick_written_node(), node_t'($urandom_range(0, 1023)),
                      1'b0, '0);
        end else if (pick < 38) begin
            // mostly linked anchors; now and then any node with written entries
            if ($urandom_range(9) == 0)
                a = pick_written_node();
            send_item(OP_QUERY, a, node_t'($urandom_range(1, 1023)), 1'b0, '0);
        end else if (n == 0 || (n < cap && $urandom_range(99) < 55)) begin
            do
                y = node_t'($urandom_range(1, NUM_NODES - 1));
            while (is_linked[y]);
            send_item(OP_INSERT, a, y, 1'b0, '0);
            linked_nodes.push_back(y);
            is_linked[y] = 1'b1;
        end else begin
            idx = $urandom_range(0, n - 1);
            a   = linked_nodes[idx];
            linked_nodes.delete(idx);
            is_linked[a] = 1'b0;
            send_item(OP_DELETE, a, node_t'($urandom_range(1, 1023)), 1'b0, '0);
        end
    endtask

    // Result checker and watchdog. Both sample outputs on the rising edge.
    // The receiver cannot stall, so each strobe is one transaction.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && busy === 1'b0) || result_valid === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("indexed_doubly_linked_list test failed");
                $finish;
            end
            if (result_valid !== 1'b0) begin
                if (pending_successors.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, successor=%0d", successor));
                end else begin
                    owed = pending_successors.pop_front();
                    if (successor !== owed)
                        report_mismatch($sformatf("successor=%0d, expected %0d",
                                                  successor, owed));
                end
            end
        end
    end

    initial begin
        node_t walk;
        int    hops;

        start           = 1'b0;
        op              = OP_INSERT;
        anchor          = '0;
        new_node        = '0;
        rst_n           = 1'b0;
        error_count     = 0;
        stall_cycles    = 0;
        sender_idle_pct = 0;

        // reset contents of the shadow stores: sentinel <-> node 1
        for (int i = 0; i < NUM_NODES; i++) begin
            nxt_link[i]  = '0;
            prv_link[i]  = '0;
            nxt_set[i]   = 1'b0;
            prv_set[i]   = 1'b0;
            is_linked[i] = 1'b0;
        end
        nxt_link[0] = 10'd1;
        prv_link[0] = 10'd1;
        nxt_set[0]  = 1'b1;
        prv_set[0]  = 1'b1;
        nxt_set[1]  = 1'b1;
        prv_set[1]  = 1'b1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; busy covers the post-reset store init
        foreach (directed_rows[r])
            send_item(directed_rows[r].op, directed_rows[r].anchor, directed_rows[r].new_node,
                      directed_rows[r].known, directed_rows[r].want);

        // rebuild the linked set by walking the shadow list from the sentinel
        walk = nxt_link[0];
        hops = 0;
        while (walk != 0 && hops < NUM_NODES) begin
            linked_nodes.push_back(walk);
            is_linked[walk] = 1'b1;
            walk = nxt_link[walk];
            hops++;
        end

        // random phases: no idling, heavy idling, light idling, heavy again;
        // the size caps alternate between shallow lists and deep ones
        sender_idle_pct = 0;
        repeat (PHASE_ITEMS) random_item(48);
        sender_idle_pct = 84;
        repeat (PHASE_ITEMS) random_item(4);
        sender_idle_pct = 31;
        repeat (PHASE_ITEMS) random_item(120);
        sender_idle_pct = 84;
        repeat (PHASE_ITEMS) random_item(16);

        // untrusted tail: any opcode, any new node, even the sentinel as
        // anchor; anchors are limited to nodes whose entries are written
        sender_idle_pct = 0;
        repeat (TAIL_ITEMS)
            send_item(OP_W'($urandom_range(0, 3)), pick_written_node(),
                      node_t'($urandom_range(0, 1023)), 1'b0, '0);

        @(negedge clk);
        start <= 1'b0;
        while (pending_successors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("indexed_doubly_linked_list test passed");
        else
            $display("indexed_doubly_linked_list test failed");
        $finish;
    end

endmodule
